### rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the XMODEM receiver.
// No dependencies; every macro expects clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked outside reset.
`define ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/core/xcr_pkg.sv
// Package for the XMODEM checksum receiver: codes, protocol bytes, state types.
// No dependencies.
package xcr_pkg;

  // input item kinds (tuser of the slave side)
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // result kinds (tuser of the master side)
  localparam logic [1:0] RK_STATUS = 2'd0;
  localparam logic [1:0] RK_TXBYTE = 2'd1;
  localparam logic [1:0] RK_WORD   = 2'd2;

  // session status
  localparam logic [1:0] SS_RUN  = 2'd0;
  localparam logic [1:0] SS_DONE = 2'd1;
  localparam logic [1:0] SS_FAIL = 2'd2;

  // protocol characters
  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CMPL_MASK = 8'hFF;

  // configuration register indexes (paddr[3:2])
  localparam logic [1:0] REG_MAX_ATTEMPTS   = 2'd0;
  localparam logic [1:0] REG_BEGIN_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_PACKET_TIMEOUT = 2'd2;

  localparam int unsigned OUT_TDATA_W = 80;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SOH  = 5'b00010,
    PH_SEQ  = 5'b00100,
    PH_CMPL = 5'b01000,
    PH_DATA = 5'b10000
  } phase_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_WRITE = 5'b00010,
    ST_RD    = 5'b00100,
    ST_WORD  = 5'b01000,
    ST_EMIT  = 5'b10000
  } fsm_e;

endpackage

### rtl/core/xmodem_checksum_receiver.sv
// XMODEM receiver (8-bit checksum): stream in, stream out, APB configuration.
// Depends on xcr_pkg and assert_macros.svh.
//
//   channel   | direction | tdata                          | tuser        | tlast
//   s_axis    | in        | rx_byte                        | kind         | -
//   m_axis    | out       | tx,payload,word_index,status   | result_kind  | last of item
//   apb       | in/out    | pwdata/prdata, 3 registers     | -            | -
//
// One item at a time. A status-only item or NAK/ACK gives a single result; a payload byte
// goes through a read of the packet store word, merge and write back, then the status result.
// CAN gives two results. A good checksum drains the store word by word (registered
// memory read then output load), then gives the ACK; output stalls hold the drain.
// rst_ni clears control state asynchronously; the packet store is not cleared.
// A stalled master side holds the output register and the sequencer in its output states.
`include "assert_macros.svh"

module xmodem_checksum_receiver #(
  parameter int unsigned PACKET_BYTES = 128
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // slave side
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] rx_byte
  input  logic [1:0]                     s_axis_tuser,  // [1:0] kind
  // master side
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [7:0] tx_byte, [71:8] payload_word, [75:72] word_index, [77:76] session_status
  output logic [xcr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // [1:0] result_kind
  output logic                           m_axis_tlast,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [3:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int unsigned WORDS = (PACKET_BYTES + 7) / 8;
  localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int unsigned CW    = $clog2(PACKET_BYTES + 1);
  localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);
  localparam logic [CW-1:0] PKT_BYTES = CW'(PACKET_BYTES);

  // ---------------------------------------------------------------- config
  logic [7:0]  max_att_q;
  logic [15:0] begin_to_q, pkt_to_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_att_q  <= 8'd10;
      begin_to_q <= 16'd3000;
      pkt_to_q   <= 16'd3000;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        xcr_pkg::REG_MAX_ATTEMPTS:   max_att_q  <= pwdata[7:0];
        xcr_pkg::REG_BEGIN_TIMEOUT:  begin_to_q <= pwdata[15:0];
        xcr_pkg::REG_PACKET_TIMEOUT: pkt_to_q   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      xcr_pkg::REG_MAX_ATTEMPTS:   prdata = {24'd0, max_att_q};
      xcr_pkg::REG_BEGIN_TIMEOUT:  prdata = {16'd0, begin_to_q};
      xcr_pkg::REG_PACKET_TIMEOUT: prdata = {16'd0, pkt_to_q};
      default:                     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- state
  xcr_pkg::fsm_e   state_q, state_d;
  xcr_pkg::phase_e phase_q, phase_d;
  logic [7:0]      block_q, block_d;
  logic [7:0]      att_q, att_d;
  logic [CW-1:0]   bcnt_q, bcnt_d;
  logic [7:0]      sum_q, sum_d;
  logic [15:0]     timer_q, timer_d;

  // pending control results of the current item
  logic [1:0]      em_kind_q, em_kind_d;
  logic [7:0]      em_tx_q, em_tx_d;
  logic [1:0]      em_cnt_q, em_cnt_d;
  logic [1:0]      status_q, status_d;
  logic [AW-1:0]   drain_q, drain_d;

  // byte write-back context
  logic [7:0]      byte_q, byte_d;
  logic [2:0]      off_q, off_d;
  logic [AW-1:0]   wr_addr_q, wr_addr_d;

  // output register
  logic                           out_valid_q, out_valid_d;
  logic [xcr_pkg::OUT_TDATA_W-1:0] out_data_q, out_data_d;
  logic [1:0]                     out_user_q, out_user_d;
  logic                           out_last_q, out_last_d;
  logic                           out_free;

  // packet store: one write and one registered read per cycle
  logic [63:0]     store_q [WORDS];
  logic [63:0]     rd_data_q;
  logic [AW-1:0]   rd_addr;
  logic            store_we;
  logic [63:0]     store_wdata;

  logic            in_accept;
  logic [7:0]      att_inc;
  logic            do_retry;

  assign s_axis_tready = (state_q == xcr_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~out_valid_q | m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;
  assign m_axis_tlast  = out_last_q;

  // saturating attempt count
  assign att_inc = (att_q == 8'hFF) ? att_q : att_q + 8'd1;

  // While idle, point at the word the next payload byte lands in; otherwise at the drain word.
  assign rd_addr = (state_q == xcr_pkg::ST_IDLE) ? bcnt_q[3 +: AW] : drain_q;

  // Merge the byte into the stored word; the first byte of a word clears the rest.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      if (off_q == 3'(j)) begin
        store_wdata[8*j +: 8] = byte_q;
      end else if (off_q == 3'd0) begin
        store_wdata[8*j +: 8] = 8'd0;
      end else begin
        store_wdata[8*j +: 8] = rd_data_q[8*j +: 8];
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    block_d     = block_q;
    att_d       = att_q;
    bcnt_d      = bcnt_q;
    sum_d       = sum_q;
    timer_d     = timer_q;
    em_kind_d   = em_kind_q;
    em_tx_d     = em_tx_q;
    em_cnt_d    = em_cnt_q;
    status_d    = status_q;
    drain_d     = drain_q;
    byte_d      = byte_q;
    off_d       = off_q;
    wr_addr_d   = wr_addr_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    out_last_d  = out_last_q;
    store_we    = 1'b0;
    do_retry    = 1'b0;

    unique case (state_q)
      xcr_pkg::ST_IDLE: begin
        if (in_accept) begin
          // default: one status-only result
          em_kind_d = xcr_pkg::RK_STATUS;
          em_tx_d   = 8'd0;
          em_cnt_d  = 2'd1;
          status_d  = xcr_pkg::SS_RUN;
          state_d   = xcr_pkg::ST_EMIT;
          if (s_axis_tuser == xcr_pkg::KIND_START) begin
            block_d   = 8'd1;
            att_d     = 8'd0;
            bcnt_d    = '0;
            sum_d     = 8'd0;
            em_kind_d = xcr_pkg::RK_TXBYTE;
            em_tx_d   = xcr_pkg::CH_NAK;
            timer_d   = begin_to_q;
            phase_d   = xcr_pkg::PH_SOH;
          end else if (s_axis_tuser == xcr_pkg::KIND_TICK &&
                       phase_q != xcr_pkg::PH_IDLE) begin
            if (timer_q <= 16'd1) begin
              timer_d  = 16'd0;
              do_retry = 1'b1;
            end else begin
              timer_d = timer_q - 16'd1;
            end
          end else if (s_axis_tuser == xcr_pkg::KIND_BYTE &&
                       phase_q != xcr_pkg::PH_IDLE) begin
            unique case (phase_q)
              xcr_pkg::PH_SOH: begin
                if (s_axis_tdata == xcr_pkg::CH_SOH) begin
                  phase_d = xcr_pkg::PH_SEQ;
                end else if (s_axis_tdata == xcr_pkg::CH_EOT) begin
                  em_kind_d = xcr_pkg::RK_TXBYTE;
                  em_tx_d   = xcr_pkg::CH_ACK;
                  status_d  = xcr_pkg::SS_DONE;
                  phase_d   = xcr_pkg::PH_IDLE;
                end
              end
              xcr_pkg::PH_SEQ: begin
                phase_d = (s_axis_tdata == block_q) ? xcr_pkg::PH_CMPL : xcr_pkg::PH_SOH;
              end
              xcr_pkg::PH_CMPL: begin
                if (s_axis_tdata == (block_q ^ xcr_pkg::CMPL_MASK)) begin
                  bcnt_d  = '0;
                  sum_d   = 8'd0;
                  timer_d = pkt_to_q;
                  phase_d = xcr_pkg::PH_DATA;
                end else begin
                  phase_d = xcr_pkg::PH_SOH;
                end
              end
              xcr_pkg::PH_DATA: begin
                if (bcnt_q < PKT_BYTES) begin
                  // read now, merge and write back next cycle
                  byte_d    = s_axis_tdata;
                  off_d     = bcnt_q[2:0];
                  wr_addr_d = bcnt_q[3 +: AW];
                  sum_d     = sum_q + s_axis_tdata;
                  bcnt_d    = bcnt_q + CW'(1);
                  state_d   = xcr_pkg::ST_WRITE;
                end else if (s_axis_tdata != sum_q) begin
                  do_retry = 1'b1;
                end else begin
                  block_d   = block_q + 8'd1;
                  att_d     = 8'd0;
                  em_kind_d = xcr_pkg::RK_TXBYTE;
                  em_tx_d   = xcr_pkg::CH_ACK;
                  timer_d   = begin_to_q;
                  phase_d   = xcr_pkg::PH_SOH;
                  drain_d   = '0;
                  state_d   = xcr_pkg::ST_RD;
                end
              end
              default: ;
            endcase
          end

          if (do_retry) begin
            att_d     = att_inc;
            em_kind_d = xcr_pkg::RK_TXBYTE;
            if (att_inc > max_att_q) begin
              em_tx_d  = xcr_pkg::CH_CAN;
              em_cnt_d = 2'd2;
              status_d = xcr_pkg::SS_FAIL;
              phase_d  = xcr_pkg::PH_IDLE;
            end else begin
              em_tx_d = xcr_pkg::CH_NAK;
              timer_d = begin_to_q;
              phase_d = xcr_pkg::PH_SOH;
            end
          end
        end
      end

      xcr_pkg::ST_WRITE: begin
        store_we = 1'b1;
        state_d  = xcr_pkg::ST_EMIT;
      end

      xcr_pkg::ST_RD: begin
        state_d = xcr_pkg::ST_WORD;
      end

      xcr_pkg::ST_WORD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_user_d  = xcr_pkg::RK_WORD;
          out_last_d  = 1'b0;
          out_data_d  = {2'b00, xcr_pkg::SS_RUN, 4'(drain_q), rd_data_q, 8'd0};
          if (drain_q == LAST_WORD) begin
            state_d = xcr_pkg::ST_EMIT;
          end else begin
            drain_d = drain_q + AW'(1);
            state_d = xcr_pkg::ST_RD;
          end
        end
      end

      xcr_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_user_d  = em_kind_q;
          out_last_d  = (em_cnt_q == 2'd1);
          out_data_d  = {2'b00, status_q, 4'd0, 64'd0, em_tx_q};
          em_cnt_d    = em_cnt_q - 2'd1;
          if (em_cnt_q == 2'd1) begin
            state_d = xcr_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = xcr_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= xcr_pkg::ST_IDLE;
      phase_q     <= xcr_pkg::PH_IDLE;
      block_q     <= 8'd1;
      att_q       <= 8'd0;
      bcnt_q      <= '0;
      sum_q       <= 8'd0;
      timer_q     <= 16'd0;
      em_kind_q   <= xcr_pkg::RK_STATUS;
      em_tx_q     <= 8'd0;
      em_cnt_q    <= 2'd0;
      status_q    <= xcr_pkg::SS_RUN;
      drain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      block_q     <= block_d;
      att_q       <= att_d;
      bcnt_q      <= bcnt_d;
      sum_q       <= sum_d;
      timer_q     <= timer_d;
      em_kind_q   <= em_kind_d;
      em_tx_q     <= em_tx_d;
      em_cnt_q    <= em_cnt_d;
      status_q    <= status_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    byte_q     <= byte_d;
    off_q      <= off_d;
    wr_addr_q  <= wr_addr_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
    out_last_q <= out_last_d;
  end

  // Each item finishes its write before the next is accepted, so no forwarding is needed.
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[wr_addr_q] <= store_wdata;
    end
    rd_data_q <= store_q[rd_addr];
  end

  // ---------------------------------------------------------------- checks
  `ASSERT_NXT(a_accept_leaves_idle, in_accept, state_q != xcr_pkg::ST_IDLE)
  `ASSERT_IMP(a_bcnt_in_range, 1'b1, bcnt_q <= PKT_BYTES)
  `ASSERT_IMP(a_drain_in_range, state_q == xcr_pkg::ST_WORD, drain_q <= LAST_WORD)

endmodule
